/* rtl/ssb_pkg.sv */
// ssb_pkg: shared types, constants and helpers for the sprite sort and batch block
// no dependencies; used by sprite_sort_and_batch
package ssb_pkg;

   localparam int MAX_SPRITES_DEF = 64;
   localparam int VERTS_PER_SPRITE = 6;
   localparam int COUNT_W = 9;

   localparam logic [1:0] MODE_TEXTURE_UP = 2'd0;
   localparam logic [1:0] MODE_DEPTH_UP = 2'd1;
   localparam logic [1:0] MODE_DEPTH_DOWN = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SORT_START,
      S_SORT_LOAD,
      S_SORT_CMP,
      S_SORT_PUT,
      S_EMIT_PREP,
      S_EMIT_RUN,
      S_EMIT_SCAN,
      S_EMIT_OUT
   } state_type;

   // six vertices per sprite, built from two shifts
   function automatic logic [COUNT_W-1:0] vertex_span(input logic [COUNT_W-1:0] sprites);
      return (sprites << 2) + (sprites << 1);
   endfunction

endpackage

/* rtl/ssb_if.sv */
// ssb_req_if / ssb_rsp_if: valid-ready channels of the sprite sort and batch block
// no dependencies
interface ssb_req_if;
   logic               valid;
   logic               ready;
   logic [31:0]        texture_id;
   logic signed [31:0] sprite_depth;
   logic               end_of_set;

   modport source (output valid, texture_id, sprite_depth, end_of_set, input ready);
   modport sink (input valid, texture_id, sprite_depth, end_of_set, output ready);
endinterface

interface ssb_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] load_position;
   logic [31:0] sprite_texture;
   logic [5:0] batch_number;
   logic       opens_batch;
   logic [8:0] batch_vertex_offset;
   logic [8:0] batch_vertex_count;
   logic       overflowed;
   logic       final_result;

   modport source (output valid, load_position, sprite_texture, batch_number, opens_batch,
                   batch_vertex_offset, batch_vertex_count, overflowed, final_result,
                   input ready);
   modport sink (input valid, load_position, sprite_texture, batch_number, opens_batch,
                 batch_vertex_offset, batch_vertex_count, overflowed, final_result,
                 output ready);
endinterface

/* rtl/sprite_sort_and_batch.sv */
// sprite_sort_and_batch: loads sprites, stable-sorts them in place and emits batch data
// depends on ssb_pkg and the channel interfaces in ssb_if.sv
//
//   channel   direction  carries
//   req_ch    in         texture_id, sprite_depth, end_of_set
//   rsp_ch    out        one sorted sprite with its batch data
//   csr_*     in         sort_mode write
//
// a sprite without end_of_set is stored if there is room and the block stays idle; ready is high only while idle
// after end_of_set an insertion sort over the n stored sprites runs on the record memory,
// shifting earlier entries up one slot until the loaded sprite fits
// the emit pass scans each batch once to find its length, then sends a result for each
// sprite of that batch
// reset is synchronous and clears control state only; the record memory is not cleared
// results go through an output register; a stalled rsp_ch holds the emit pass
module sprite_sort_and_batch #(
   parameter int MAX_SPRITES = ssb_pkg::MAX_SPRITES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ssb_req_if.sink           req_ch,
   ssb_rsp_if.source         rsp_ch,
   input  logic              csr_write_en,
   input  logic [1:0]        csr_write_data
);

   localparam int IW = (MAX_SPRITES > 1) ? $clog2(MAX_SPRITES) : 1;
   localparam int CW = $clog2(MAX_SPRITES + 1);
   localparam int VW = ssb_pkg::COUNT_W;

   typedef struct packed {
      logic [IW-1:0]      pos;
      logic [31:0]        tex;
      logic signed [31:0] dep;
   } rec_type;

   rec_type rec_mem [MAX_SPRITES];

   ssb_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [1:0]    sort_mode_ff;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, ptr_ff, ptr_in;
   logic [IW-1:0] e_ff, e_in, s_ff, s_in, k_ff, k_in, batch_ff, batch_in;
   logic [CW-1:0] len_ff, len_in;
   logic [31:0]   run_tex_ff, run_tex_in;
   rec_type       cur_ff, cur_in, rd_ff;

   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   rec_type       mem_wdata;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_load;
   logic [5:0]    out_pos_ff, out_batch_ff;
   logic [31:0]   out_tex_ff;
   logic          out_opens_ff, out_ovf_ff, out_final_ff;
   logic [VW-1:0] out_offset_ff, out_vcount_ff;

   logic accept, goes_first, match, slot_free;
   logic i_last, e_last, k_last, run_end, j_one, has_room;

   assign accept    = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ssb_pkg::S_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign match     = (rd_ff.tex == run_tex_ff);
   assign i_last    = (CW'(i_ff) + CW'(1)) == count_ff;
   assign e_last    = (CW'(e_ff) + CW'(1)) == count_ff;
   assign k_last    = (CW'(k_ff) + CW'(1)) == count_ff;
   assign run_end   = (CW'(e_ff) + CW'(1)) == (CW'(s_ff) + len_ff);
   assign j_one     = (j_ff == IW'(1));
   assign has_room  = count_ff < CW'(MAX_SPRITES);

   // strict order keeps equal keys in load order; unused mode sorts by texture
   always_comb begin
      priority if (sort_mode_ff == ssb_pkg::MODE_DEPTH_UP) begin
         goes_first = cur_ff.dep < rd_ff.dep;
      end else if (sort_mode_ff == ssb_pkg::MODE_DEPTH_DOWN) begin
         goes_first = cur_ff.dep > rd_ff.dep;
      end else begin
         goes_first = cur_ff.tex < rd_ff.tex;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ssb_pkg::S_IDLE: begin
            if (accept && req_ch.end_of_set) state_in = ssb_pkg::S_SORT_START;
         end
         ssb_pkg::S_SORT_START: begin
            state_in = (count_ff == CW'(1)) ? ssb_pkg::S_EMIT_PREP : ssb_pkg::S_SORT_LOAD;
         end
         ssb_pkg::S_SORT_LOAD: state_in = ssb_pkg::S_SORT_CMP;
         ssb_pkg::S_SORT_CMP: begin
            if (goes_first) begin
               if (j_one) state_in = ssb_pkg::S_SORT_PUT;
            end else begin
               state_in = i_last ? ssb_pkg::S_EMIT_PREP : ssb_pkg::S_SORT_LOAD;
            end
         end
         ssb_pkg::S_SORT_PUT: begin
            state_in = i_last ? ssb_pkg::S_EMIT_PREP : ssb_pkg::S_SORT_LOAD;
         end
         ssb_pkg::S_EMIT_PREP: state_in = ssb_pkg::S_EMIT_RUN;
         ssb_pkg::S_EMIT_RUN: begin
            state_in = e_last ? ssb_pkg::S_EMIT_OUT : ssb_pkg::S_EMIT_SCAN;
         end
         ssb_pkg::S_EMIT_SCAN: begin
            if (!match || k_last) state_in = ssb_pkg::S_EMIT_OUT;
         end
         ssb_pkg::S_EMIT_OUT: begin
            if (slot_free) begin
               if (e_last) state_in = ssb_pkg::S_IDLE;
               else if (run_end) state_in = ssb_pkg::S_EMIT_RUN;
            end
         end
         default: state_in = ssb_pkg::S_IDLE;
      endcase
   end

   // datapath and memory control; rd_ff always shows the entry at ptr_ff
   always_comb begin
      count_in   = count_ff;
      ovf_in     = ovf_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      ptr_in     = ptr_ff;
      e_in       = e_ff;
      s_in       = s_ff;
      k_in       = k_ff;
      batch_in   = batch_ff;
      len_in     = len_ff;
      run_tex_in = run_tex_ff;
      cur_in     = cur_ff;
      mem_we     = 1'b0;
      mem_waddr  = j_ff;
      mem_wdata  = cur_ff;
      out_load   = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         ssb_pkg::S_IDLE: begin
            if (accept) begin
               if (has_room) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IW-1:0];
                  mem_wdata.pos = count_ff[IW-1:0];
                  mem_wdata.tex = req_ch.texture_id;
                  mem_wdata.dep = req_ch.sprite_depth;
                  count_in  = count_ff + CW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ssb_pkg::S_SORT_START: begin
            i_in   = IW'(1);
            ptr_in = IW'(1);
         end
         ssb_pkg::S_SORT_LOAD: begin
            cur_in = rd_ff;
            j_in   = i_ff;
            ptr_in = i_ff - IW'(1);
         end
         ssb_pkg::S_SORT_CMP: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            if (goes_first) begin
               // shift the entry that cur must precede up one slot
               mem_wdata = rd_ff;
               j_in      = j_ff - IW'(1);
               ptr_in    = j_ff - IW'(2);
            end else begin
               mem_wdata = cur_ff;
               i_in      = i_ff + IW'(1);
               ptr_in    = i_ff + IW'(1);
            end
         end
         ssb_pkg::S_SORT_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = cur_ff;
            i_in      = i_ff + IW'(1);
            ptr_in    = i_ff + IW'(1);
         end
         ssb_pkg::S_EMIT_PREP: begin
            ptr_in   = '0;
            e_in     = '0;
            s_in     = '0;
            batch_in = '0;
         end
         ssb_pkg::S_EMIT_RUN: begin
            run_tex_in = rd_ff.tex;
            len_in     = CW'(1);
            k_in       = s_ff + IW'(1);
            ptr_in     = e_last ? s_ff : s_ff + IW'(1);
         end
         ssb_pkg::S_EMIT_SCAN: begin
            if (match) begin
               len_in = len_ff + CW'(1);
               k_in   = k_ff + IW'(1);
            end
            ptr_in = (match && !k_last) ? k_ff + IW'(1) : s_ff;
         end
         ssb_pkg::S_EMIT_OUT: begin
            if (slot_free) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (e_last) begin
                  count_in = '0;
                  ovf_in   = 1'b0;
               end else begin
                  e_in   = e_ff + IW'(1);
                  ptr_in = e_ff + IW'(1);
                  if (run_end) begin
                     s_in     = e_ff + IW'(1);
                     batch_in = batch_ff + IW'(1);
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssb_pkg::S_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         sort_mode_ff <= ssb_pkg::MODE_TEXTURE_UP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) sort_mode_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      ptr_ff     <= ptr_in;
      e_ff       <= e_in;
      s_ff       <= s_in;
      k_ff       <= k_in;
      batch_ff   <= batch_in;
      len_ff     <= len_in;
      run_tex_ff <= run_tex_in;
      cur_ff     <= cur_in;
   end

   // record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) rec_mem[mem_waddr] <= mem_wdata;
      rd_ff <= rec_mem[ptr_in];
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_pos_ff    <= 6'(rd_ff.pos);
         out_tex_ff    <= rd_ff.tex;
         out_batch_ff  <= 6'(batch_ff);
         out_opens_ff  <= (e_ff == s_ff);
         out_offset_ff <= ssb_pkg::vertex_span(VW'(s_ff));
         out_vcount_ff <= ssb_pkg::vertex_span(VW'(len_ff));
         out_ovf_ff    <= ovf_ff;
         out_final_ff  <= e_last;
      end
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.load_position       = out_pos_ff;
   assign rsp_ch.sprite_texture      = out_tex_ff;
   assign rsp_ch.batch_number        = out_batch_ff;
   assign rsp_ch.opens_batch         = out_opens_ff;
   assign rsp_ch.batch_vertex_offset = out_offset_ff;
   assign rsp_ch.batch_vertex_count  = out_vcount_ff;
   assign rsp_ch.overflowed          = out_ovf_ff;
   assign rsp_ch.final_result        = out_final_ff;

endmodule
